// File: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the checker module
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising edge outside reset
`define ASSERT_PROP(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("assertion failed");

// condition that must never hold outside reset
`define ASSERT_NEVER(label, clk, rst_n, cond) \
  `ASSERT_PROP(label, clk, rst_n, !(cond))

`endif

// File: rtl/nsr_pkg.sv
// ---------------------------------------------------------------------------
// nsr_pkg
// shared types and constants of the newton square root block
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package nsr_pkg;

  // configuration register file
  localparam int TOL_W      = 16;
  localparam int LIMIT_W    = 6;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ITER_LIMIT = 1'd1;

  localparam logic [TOL_W-1:0]   TOL_RESET   = 16'd0;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 6'd32;

  // result width and saturation value
  localparam int              ROOT_W   = 24;
  localparam logic [ROOT_W-1:0] ROOT_MAX = 24'hFF_FFFF;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;        // capture radicand, set start estimate
    logic sq_start;    // set up the shift-add square of the estimate
    logic sq_step;     // one multiplier bit
    logic div_start;   // set up the restoring division
    logic div_step;    // one quotient bit
    logic update;      // x <- (x + q) / 2
    logic out_load;    // capture the result register
    logic res_invalid;
    logic res_limit;
  } nsr_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic in_neg;      // radicand at the input port is negative
    logic x_zero;      // current estimate is zero
    logic above_tol;   // x*x exceeds (radicand + tolerance) scaled
  } nsr_status_t;

endpackage

// File: rtl/nsr_datapath.sv
// ---------------------------------------------------------------------------
// nsr_datapath
// estimate register, bit-serial squarer, restoring divider, result register
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module nsr_datapath import nsr_pkg::*; #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                  clk_i,
  input  logic [DATA_WIDTH-1:0] radicand_i,
  input  logic [TOL_W-1:0]      tolerance_i,
  input  nsr_cmd_t              cmd_i,
  output nsr_status_t           status_o,
  output logic [ROOT_W-1:0]     root_o,
  output logic                  invalid_o,
  output logic                  limit_reached_o
);

  // estimate width: holds the radicand and 1.0
  localparam int XW = (DATA_WIDTH > FRAC_BITS + 1) ? DATA_WIDTH : FRAC_BITS + 1;
  localparam int CW = 2 * XW;                  // square width
  localparam int NW = DATA_WIDTH + FRAC_BITS;  // scaled dividend width

  localparam logic [XW-1:0] ONE_FIX = XW'(1) << FRAC_BITS;

  logic [DATA_WIDTH-1:0] v_q;
  logic [XW-1:0]         x_q;
  logic [CW-1:0]         acc_q, mcand_q;
  logic [XW-1:0]         mplier_q;
  logic [XW-1:0]         rem_q;
  logic [NW-1:0]         quo_q;

  logic [XW-1:0]         v_ext;
  logic [DATA_WIDTH:0]   m_sum;
  logic [CW-1:0]         rhs;
  logic [XW:0]           trial, div_ext;
  logic                  trial_ge;
  logic [DATA_WIDTH-1:0] q_sat;
  logic [XW:0]           x_sum;
  logic [XW+ROOT_W-1:0]  x_wide;
  logic [ROOT_W-1:0]     root_sat;

  assign v_ext = {{(XW-DATA_WIDTH){1'b0}}, radicand_i};

  // (radicand + tolerance) << frac, compared with x*x
  assign m_sum = {1'b0, v_q} + {{(DATA_WIDTH+1-TOL_W){1'b0}}, tolerance_i};
  assign rhs   = {{(CW-DATA_WIDTH-1){1'b0}}, m_sum} << FRAC_BITS;

  // restoring division step
  assign trial    = {rem_q, quo_q[NW-1]};
  assign div_ext  = {1'b0, x_q};
  assign trial_ge = (trial >= div_ext);

  // quotient clipped to the data range
  assign q_sat = (|quo_q[NW-1:DATA_WIDTH]) ? '1 : quo_q[DATA_WIDTH-1:0];
  assign x_sum = {1'b0, x_q} + {{(XW+1-DATA_WIDTH){1'b0}}, q_sat};

  assign x_wide   = {{ROOT_W{1'b0}}, x_q};
  assign root_sat = (x_wide > {{XW{1'b0}}, ROOT_MAX}) ? ROOT_MAX : x_wide[ROOT_W-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      v_q <= radicand_i;
      x_q <= (v_ext > ONE_FIX) ? v_ext : ONE_FIX;
    end else if (cmd_i.update) begin
      x_q <= x_sum[XW:1];
    end

    if (cmd_i.sq_start) begin
      acc_q    <= '0;
      mcand_q  <= {{XW{1'b0}}, x_q};
      mplier_q <= x_q;
    end else if (cmd_i.sq_step) begin
      if (mplier_q[0]) begin
        acc_q <= acc_q + mcand_q;
      end
      mcand_q  <= mcand_q << 1;
      mplier_q <= mplier_q >> 1;
    end

    if (cmd_i.div_start) begin
      rem_q <= '0;
      quo_q <= {v_q, {FRAC_BITS{1'b0}}};
    end else if (cmd_i.div_step) begin
      rem_q <= trial_ge ? XW'(trial - div_ext) : trial[XW-1:0];
      quo_q <= {quo_q[NW-2:0], trial_ge};
    end

    if (cmd_i.out_load) begin
      root_o          <= cmd_i.res_invalid ? '0 : root_sat;
      invalid_o       <= cmd_i.res_invalid;
      limit_reached_o <= cmd_i.res_limit;
    end
  end

  assign status_o.in_neg    = radicand_i[DATA_WIDTH-1];
  assign status_o.x_zero    = (x_q == '0);
  assign status_o.above_tol = (acc_q > rhs);

endmodule

// File: rtl/nsr_ctrl.sv
// ---------------------------------------------------------------------------
// nsr_ctrl
// sequencer for the newton iterations and the output handshake
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module nsr_ctrl import nsr_pkg::*; #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  input  logic [LIMIT_W-1:0] iteration_limit_i,
  input  nsr_status_t        status_i,
  output nsr_cmd_t           cmd_o
);

  localparam int XW    = (DATA_WIDTH > FRAC_BITS + 1) ? DATA_WIDTH : FRAC_BITS + 1;
  localparam int NW    = DATA_WIDTH + FRAC_BITS;
  localparam int CNT_W = $clog2(NW);

  localparam logic [CNT_W-1:0] SQ_LAST  = CNT_W'(XW - 1);
  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(NW - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SQUARE,
    ST_TEST,
    ST_DIVIDE,
    ST_UPDATE,
    ST_WRITE
  } state_e;

  state_e             state_q;
  logic [CNT_W-1:0]   step_q;
  logic [LIMIT_W-1:0] iter_q;
  logic               res_invalid_q, res_limit_q;
  logic               out_valid_q;
  logic               accept, out_free;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign accept      = in_valid_i && (state_q == ST_IDLE);
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o             = '0;
    cmd_o.res_invalid = res_invalid_q;
    cmd_o.res_limit   = res_limit_q;
    unique case (state_q)
      ST_IDLE:   cmd_o.load      = accept;
      ST_CHECK:  cmd_o.sq_start  = !status_i.x_zero;
      ST_SQUARE: cmd_o.sq_step   = 1'b1;
      ST_TEST:   cmd_o.div_start = status_i.above_tol && (iter_q < iteration_limit_i);
      ST_DIVIDE: cmd_o.div_step  = 1'b1;
      ST_UPDATE: cmd_o.update    = 1'b1;
      ST_WRITE:  cmd_o.out_load  = out_free;
      default:   cmd_o.load      = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      step_q        <= '0;
      iter_q        <= '0;
      res_invalid_q <= 1'b0;
      res_limit_q   <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      if (state_q == ST_WRITE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            iter_q        <= '0;
            res_invalid_q <= status_i.in_neg;
            res_limit_q   <= 1'b0;
            state_q       <= status_i.in_neg ? ST_WRITE : ST_CHECK;
          end
        end
        ST_CHECK: begin
          step_q  <= '0;
          state_q <= status_i.x_zero ? ST_WRITE : ST_SQUARE;
        end
        ST_SQUARE: begin
          step_q <= step_q + 1'b1;
          if (step_q == SQ_LAST) begin
            state_q <= ST_TEST;
          end
        end
        ST_TEST: begin
          step_q <= '0;
          if (!status_i.above_tol) begin
            state_q <= ST_WRITE;
          end else if (iter_q >= iteration_limit_i) begin
            res_limit_q <= 1'b1;
            state_q     <= ST_WRITE;
          end else begin
            state_q <= ST_DIVIDE;
          end
        end
        ST_DIVIDE: begin
          step_q <= step_q + 1'b1;
          if (step_q == DIV_LAST) begin
            state_q <= ST_UPDATE;
          end
        end
        ST_UPDATE: begin
          iter_q  <= iter_q + 1'b1;
          state_q <= ST_CHECK;
        end
        ST_WRITE: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/newton_square_root.sv
// sequence: accept, then per newton update an XW-bit square, test, NW-bit divide, update; then write;
//   negative radicands go to write (XW = max(DATA_WIDTH, FRAC_BITS+1), NW = DATA_WIDTH+FRAC_BITS)
// throughput: one transaction at a time, the next is taken once the result is in the output register
// the bit-serial squarer and the one-bit-per-cycle restoring divider set the per-update cost
// reset: asynchronous active low, clears control state, tolerance 0, iteration limit 32
`timescale 1ns / 1ps

// ---------------------------------------------------------------------------
// newton_square_root
// fixed point square root by newton-raphson iteration with tolerance and cap
// ---------------------------------------------------------------------------

module newton_square_root import nsr_pkg::*; #(
  parameter int FRAC_BITS  = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration write port
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  // input transaction
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [DATA_WIDTH-1:0] radicand_i,
  // result transaction
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [ROOT_W-1:0]     root_o,
  output logic                  invalid_o,
  output logic                  limit_reached_o
);

  logic [TOL_W-1:0]   tolerance_q;
  logic [LIMIT_W-1:0] iteration_limit_q;
  nsr_cmd_t           cmd;
  nsr_status_t        status;

  // configuration registers, to be written only while no transaction is in flight; unchecked
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tolerance_q       <= TOL_RESET;
      iteration_limit_q <= LIMIT_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_TOLERANCE:  tolerance_q       <= cfg_wdata_i[TOL_W-1:0];
        REG_ITER_LIMIT: iteration_limit_q <= cfg_wdata_i[LIMIT_W-1:0];
        default:        tolerance_q       <= tolerance_q;
      endcase
    end
  end

  // sequencer: accept, per-update loop of square, test, divide, update, then output
  nsr_ctrl #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_ctrl (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .iteration_limit_i (iteration_limit_q),
    .status_i          (status),
    .cmd_o             (cmd)
  );

  // estimate, squarer, divider and result register
  nsr_datapath #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_datapath (
    .clk_i           (clk_i),
    .radicand_i      (radicand_i),
    .tolerance_i     (tolerance_q),
    .cmd_i           (cmd),
    .status_o        (status),
    .root_o          (root_o),
    .invalid_o       (invalid_o),
    .limit_reached_o (limit_reached_o)
  );

endmodule

// File: rtl/nsr_checker.sv
// ---------------------------------------------------------------------------
// nsr_checker
// port-level checks of the newton square root block
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module nsr_checker import nsr_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic [ROOT_W-1:0] root_o,
  input logic              invalid_o,
  input logic              limit_reached_o
);

  // a stalled result stays offered
  `ASSERT_PROP(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i |=> out_valid_o)

  // a negative radicand gives root zero and no cap flag
  `ASSERT_NEVER(a_invalid_clean, clk_i, rst_ni,
                out_valid_o && invalid_o && ((root_o != '0) || limit_reached_o))

  // one transaction at a time: busy right after an accept
  `ASSERT_PROP(a_busy_after_accept, clk_i, rst_ni, in_valid_i && !in_stall_o |=> in_stall_o)

  // a new result only appears after the block was busy
  `ASSERT_PROP(a_result_from_work, clk_i, rst_ni, $rose(out_valid_o) |-> $past(in_stall_o))

endmodule

bind newton_square_root nsr_checker u_nsr_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_stall_o      (in_stall_o),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .root_o          (root_o),
  .invalid_o       (invalid_o),
  .limit_reached_o (limit_reached_o)
);

// File: sim/testbench.sv
`timescale 1ns / 1ps

// ---------------------------------------------------------------------------
// testbench
// checks the newton square root block against a predictor that is built into
// this bench: directed corner radicands, then random traffic under several
// tolerance and iteration cap settings, with random gaps and output stalls
// ---------------------------------------------------------------------------

module testbench;
  import nsr_pkg::*;

  localparam int          FRAC_BITS     = 16;
  localparam int          DATA_WIDTH    = 32;
  localparam logic [63:0] ONE_FIX       = 64'd1 << FRAC_BITS;
  localparam logic [63:0] DATA_MAX      = (64'd1 << DATA_WIDTH) - 64'd1;
  // bound sized for the worst item: 63 updates plus overhead, long gap and stall,
  // about 1600 items, then several times that
  localparam int          MAX_CYCLES    = 30_000_000;
  localparam int          SETTLE_CYCLES = 8;
  localparam int          REPORT_LIMIT  = 10;

  // one predicted result, with the radicand kept for reports
  typedef struct packed {
    logic [DATA_WIDTH-1:0] radicand;
    logic [ROOT_W-1:0]     root;
    logic                  invalid;
    logic                  limit_reached;
  } sqrt_result_t;

  logic                  clk_i;
  logic                  rst_ni       = 1'b0;
  logic                  cfg_we_i     = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i    = REG_TOLERANCE;
  logic [CFG_DATA_W-1:0] cfg_wdata_i  = '0;
  logic                  in_valid_i   = 1'b0;
  logic                  in_stall_o;
  logic [DATA_WIDTH-1:0] radicand_i   = '0;
  logic                  out_valid_o;
  logic                  out_stall_i  = 1'b0;
  logic [ROOT_W-1:0]     root_o;
  logic                  invalid_o;
  logic                  limit_reached_o;

  // predictor copy of the register file
  logic [15:0]    tolerance_setting = TOL_RESET;
  logic [5:0]     cap_setting       = LIMIT_RESET;

  sqrt_result_t   roots_pending[$];
  bit             gaps_on   = 1'b1;
  bit             stalls_on = 1'b1;
  int unsigned    stall_left;
  int unsigned    cycle_count;
  int unsigned    fail_count;
  int unsigned    items_sent;
  int unsigned    roots_checked;
  int unsigned    invalid_seen;
  int unsigned    capped_seen;
  int unsigned    saturated_seen;
  int unsigned    settings_used = 1;

  newton_square_root #(
    .FRAC_BITS (FRAC_BITS),
    .DATA_WIDTH(DATA_WIDTH)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .radicand_i     (radicand_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .root_o         (root_o),
    .invalid_o      (invalid_o),
    .limit_reached_o(limit_reached_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // ------------------------------------------------------------------------
  // predictor
  // ------------------------------------------------------------------------

  // newton iteration from max(radicand, 1.0), exact stop test in the wide
  // product domain, quotient saturated to the data width
  function automatic sqrt_result_t predict_sqrt(logic [DATA_WIDTH-1:0] rad);
    logic [63:0]  value;
    logic [63:0]  estimate;
    logic [63:0]  quotient;
    logic [127:0] square;
    logic [127:0] bound;
    int unsigned  updates;
    bit           done;
    sqrt_result_t res;
    res          = '0;
    res.radicand = rad;
    if (rad[DATA_WIDTH-1]) begin
      // negative radicand: flagged, no iteration at all
      res.invalid = 1'b1;
      return res;
    end
    value    = {32'b0, rad};
    estimate = (value > ONE_FIX) ? value : ONE_FIX;
    updates  = 0;
    done     = 1'b0;
    while (!done) begin
      square = {64'b0, estimate} * {64'b0, estimate};
      bound  = ({64'b0, value} + {112'b0, tolerance_setting}) << FRAC_BITS;
      if (estimate == 64'd0 || square <= bound) begin
        // zero estimate or within tolerance
        done = 1'b1;
      end else if (updates >= cap_setting) begin
        res.limit_reached = 1'b1;
        done              = 1'b1;
      end else begin
        quotient = (value << FRAC_BITS) / estimate;
        if (quotient > DATA_MAX) quotient = DATA_MAX;
        estimate = (estimate + quotient) >> 1;
        updates++;
      end
    end
    res.root = (estimate > ROOT_MAX) ? ROOT_MAX : estimate[ROOT_W-1:0];
    return res;
  endfunction

  // mostly short waits, now and then a long one
  function automatic int unsigned pick_delay();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  // radicand classes that reach different parts of the iteration
  function automatic logic [DATA_WIDTH-1:0] pick_radicand();
    logic [15:0] side;
    case ($urandom_range(0, 6))
      0: return $urandom;
      1: return {1'b1, 31'($urandom)};
      2: return $urandom_range(0, 'hFFFF);
      3: return $urandom_range(0, 'h10_0000);
      4: begin
        side = 16'($urandom_range(0, 46340));
        return 32'(side) * 32'(side);
      end
      5: return $urandom_range('h4000_0000, 'h7FFF_FFFF);
      default: return $urandom_range(0, 'h7FFF_FFFF);
    endcase
  endfunction

  // ------------------------------------------------------------------------
  // result checker and output stall generator
  // ------------------------------------------------------------------------

  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= REPORT_LIMIT) $display("mismatch: %s", msg);
  endtask

  always @(posedge clk_i) begin : check_results
    sqrt_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (roots_pending.size() == 0) begin
        note_failure($sformatf("unexpected result root=%h invalid=%b limit=%b",
                               root_o, invalid_o, limit_reached_o));
      end else begin
        want = roots_pending.pop_front();
        roots_checked++;
        if (want.invalid) invalid_seen++;
        if (want.limit_reached) capped_seen++;
        if (want.root == ROOT_MAX) saturated_seen++;
        if (root_o !== want.root || invalid_o !== want.invalid ||
            limit_reached_o !== want.limit_reached) begin
          note_failure($sformatf(
            "radicand %h: expected root=%h invalid=%b limit=%b, got root=%h invalid=%b limit=%b",
            want.radicand, want.root, want.invalid, want.limit_reached,
            root_o, invalid_o, limit_reached_o));
        end
      end
    end
    // stall bursts of random length, off while stalls_on is clear
    if (stall_left != 0) begin
      stall_left  <= stall_left - 1;
      out_stall_i <= 1'b1;
    end else if (stalls_on && $urandom_range(0, 3) == 0) begin
      stall_left  <= pick_delay();
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= MAX_CYCLES) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, roots_pending.size());
      $display("FAIL newton_square_root");
      $finish;
    end
  end

  // ------------------------------------------------------------------------
  // stimulus helpers
  // ------------------------------------------------------------------------

  // one input transaction; valid stays high if the next one follows at once
  task automatic send_radicand(input logic [DATA_WIDTH-1:0] value);
    int unsigned gap;
    gap = gaps_on ? pick_delay() : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      radicand_i <= $urandom;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    radicand_i <= value;
    do @(posedge clk_i); while (in_stall_o);
    roots_pending.push_back(predict_sqrt(value));
    items_sent++;
  endtask

  // drop valid and let every outstanding result come back
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (roots_pending.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // write both registers while the block is idle; the cap word may carry
  // junk above bit 5, which the register drops
  task automatic set_registers(input logic [15:0] tol_word, input logic [15:0] cap_word);
    drain_results();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= REG_TOLERANCE;
    cfg_wdata_i <= tol_word;
    @(posedge clk_i);
    cfg_idx_i   <= REG_ITER_LIMIT;
    cfg_wdata_i <= cap_word;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    cfg_wdata_i <= 16'($urandom);
    tolerance_setting = tol_word;
    cap_setting       = cap_word[5:0];
    settings_used++;
  endtask

  task automatic send_random_items(input int unsigned count);
    repeat (count) send_radicand(pick_radicand());
  endtask

  // ------------------------------------------------------------------------
  // tests
  // ------------------------------------------------------------------------

  // reset settings: zero tolerance, cap of 32
  task automatic test_reset_defaults();
    logic [DATA_WIDTH-1:0] corner[$];
    corner = '{32'h0000_0000,   // zero radicand, estimate halves down to zero
               32'h0000_0001, 32'h0000_FFFF, 32'h0001_0000, 32'h0001_0001,
               32'h0004_0000, 32'h0009_0000, 32'h2710_0000,
               32'h7FFF_FFFF, 32'h5555_5555, 32'h2AAA_AAAA,
               32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_0000};
    foreach (corner[i]) send_radicand(corner[i]);
  endtask

  // widest tolerance with the highest cap, then a cap of one so that large
  // radicands stop above the root range and saturate
  task automatic test_tolerance_and_cap_extremes();
    set_registers(16'hFFFF, 16'd63);
    send_radicand(32'h0000_0000);
    send_radicand(32'h0000_0001);
    send_radicand(32'h0001_2345);
    send_radicand(32'h7FFF_FFFF);
    set_registers(16'h0000, 16'hFFC1);
    send_radicand(32'h7FFF_FFFF);
    send_radicand(32'h4000_0000);
    send_radicand(32'h0002_0000);
    send_radicand(32'h8000_0001);
  endtask

  // a cap of zero: no update is made, flagged unless the start value fits
  task automatic test_zero_iteration_limit();
    set_registers(16'h0000, 16'hFFC0);
    send_radicand(32'h0001_0000);
    send_radicand(32'h0002_0000);
    send_radicand(32'h0000_0000);
    send_radicand(32'h7FFF_FFFF);
    set_registers(16'hFFFF, 16'h0000);
    send_radicand(32'h0000_FFFF);
    send_radicand(32'hFFFF_FFFF);
  endtask

  // random radicands under a series of settings, idling varied per phase
  task automatic test_random_traffic();
    set_registers(TOL_RESET, 16'(LIMIT_RESET));
    send_random_items(400);

    // a stretch with no idling on either side
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    set_registers(16'hFFFF, 16'd63);
    send_random_items(300);

    gaps_on = 1'b1;
    set_registers(16'h0000, {10'($urandom), 6'd1});
    send_random_items(150);

    stalls_on = 1'b1;
    set_registers(16'($urandom), {10'($urandom), 6'd0});
    send_random_items(100);

    repeat (5) begin
      set_registers(16'($urandom), {10'($urandom), 6'($urandom_range(1, 63))});
      send_random_items(110);
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_tolerance_and_cap_extremes();
    test_zero_iteration_limit();
    test_random_traffic();
    drain_results();

    $display("%0d radicands sent under %0d register settings, %0d roots checked",
             items_sent, settings_used, roots_checked);
    $display("%0d negative, %0d hit the cap, %0d saturated, %0d mismatches",
             invalid_seen, capped_seen, saturated_seen, fail_count);
    if (fail_count == 0 && roots_pending.size() == 0) begin
      $display("PASS newton_square_root");
    end else begin
      $display("FAIL newton_square_root");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl
rtl/nsr_pkg.sv
rtl/nsr_datapath.sv
rtl/nsr_ctrl.sv
rtl/newton_square_root.sv
rtl/nsr_checker.sv
sim/testbench.sv
